// File: hdl/far_pkg.sv
// Package for the fraction arithmetic and reduction unit.
// Shared widths, operation codes and the front-to-back job type. No dependencies.
package far_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int DEN_WIDTH   = VALUE_WIDTH - 1;
	localparam int MAG_WIDTH   = 2 * VALUE_WIDTH;
	localparam int RES_NUM_W   = 32;
	localparam int RES_DEN_W   = 31;
	localparam int QDEPTH      = 2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// classified job handed from front to back
	typedef struct packed {
		logic                 err;
		logic                 neg;
		logic [MAG_WIDTH-1:0] mag;
		logic [MAG_WIDTH-1:0] den;
	} job_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_MUL,
		FS_SUM,
		FS_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_GCD,
		BS_DIVN,
		BS_DIVD,
		BS_OUT
	} back_state_t;

endpackage

// File: hdl/far_front.sv
// Front part: accepts an item, forms cross products in its multiply state and
// classifies it into a job for the queue. Depends on far_pkg.
module far_front import far_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [1:0]             kind,
	input  logic [VALUE_WIDTH-1:0] a_num,
	input  logic [DEN_WIDTH-1:0]   a_den,
	input  logic [VALUE_WIDTH-1:0] b_num,
	input  logic [DEN_WIDTH-1:0]   b_den,
	output logic                   busy,
	output logic                   push,
	output job_t                   job,
	input  logic                   q_full
);

	front_state_t state_q, state_d;
	op_t                  kind_q;
	logic                 an_q, bn_q;
	logic [VALUE_WIDTH-1:0] am_q, bm_q;
	logic [DEN_WIDTH-1:0] ad_q, bd_q;
	logic [MAG_WIDTH-1:0] p_q, q_q, d_q;
	job_t                 job_q;
	logic                 accept;

	function automatic logic [VALUE_WIDTH-1:0] mag_of(input logic [VALUE_WIDTH-1:0] v);
		mag_of = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	assign accept = start && !busy;
	assign busy   = (state_q != FS_IDLE);
	assign push   = (state_q == FS_PUSH) && !q_full;
	assign job    = job_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: if (accept) state_d = FS_MUL;
			FS_MUL:  state_d = FS_SUM;
			FS_SUM:  state_d = FS_PUSH;
			FS_PUSH: if (!q_full) state_d = FS_IDLE;
			default: state_d = FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FS_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= op_t'(kind);
			an_q   <= a_num[VALUE_WIDTH-1];
			bn_q   <= b_num[VALUE_WIDTH-1];
			am_q   <= mag_of(a_num);
			bm_q   <= mag_of(b_num);
			ad_q   <= a_den;
			bd_q   <= b_den;
		end
		if (state_q == FS_MUL) begin
			// one multiplier per product, registered before the sum
			case (kind_q)
				OP_MUL: begin
					p_q <= MAG_WIDTH'(am_q) * MAG_WIDTH'(bm_q);
					d_q <= MAG_WIDTH'(ad_q) * MAG_WIDTH'(bd_q);
				end
				OP_DIV: begin
					p_q <= MAG_WIDTH'(am_q) * MAG_WIDTH'(bd_q);
					d_q <= MAG_WIDTH'(ad_q) * MAG_WIDTH'(bm_q);
				end
				default: begin
					p_q <= MAG_WIDTH'(am_q) * MAG_WIDTH'(bd_q);
					d_q <= MAG_WIDTH'(ad_q) * MAG_WIDTH'(bd_q);
				end
			endcase
			q_q <= MAG_WIDTH'(bm_q) * MAG_WIDTH'(ad_q);
		end
		if (state_q == FS_SUM) begin
			job_q.den <= d_q;
			job_q.err <= (ad_q == '0) || (bd_q == '0) ||
				((kind_q == OP_DIV) && (bm_q == '0));
			case (kind_q)
				OP_ADD, OP_SUB: begin
					logic qn;
					qn = (kind_q == OP_SUB) ? !bn_q : bn_q;
					if (an_q == qn) begin
						job_q.mag <= p_q + q_q;
						job_q.neg <= an_q;
					end else if (p_q >= q_q) begin
						job_q.mag <= p_q - q_q;
						job_q.neg <= an_q;
					end else begin
						job_q.mag <= q_q - p_q;
						job_q.neg <= qn;
					end
				end
				default: begin
					job_q.mag <= p_q;
					job_q.neg <= an_q != bn_q;
				end
			endcase
		end
	end

endmodule

// File: hdl/far_queue.sv
// Short job queue between front and back parts.
// Depends on far_pkg.
module far_queue import far_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	input  logic pop,
	output job_t rdata,
	output logic empty,
	output logic full
);

	localparam int AW = $clog2(QDEPTH);

	job_t           mem_q [QDEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [AW:0]    cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (AW+1)'(QDEPTH));
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(QDEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(QDEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

// File: hdl/far_back.sv
// Back part: Euclid by shared restoring divider, then both parts divided by
// the GCD, then one result strobe; errors and zero skip to the strobe. Depends on far_pkg.
module far_back import far_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  job_t                  job,
	output logic                  pop,
	output logic                  done,
	output logic [RES_NUM_W-1:0]  res_num,
	output logic [RES_DEN_W-1:0]  res_den,
	output logic                  status
);

	localparam int CW = $clog2(MAG_WIDTH + 1);

	back_state_t state_q, state_d;
	logic                 neg_q;
	logic [MAG_WIDTH-1:0] mag_q, den_q, x_q, y_q;
	// shared bit-serial divider
	logic [MAG_WIDTH-1:0] dvd_q, dvs_q, quo_q, rem_q;
	logic [CW-1:0]        cnt_q;
	logic                 div_run_q;
	logic [MAG_WIDTH:0]   trial;
	logic [MAG_WIDTH-1:0] n_out;
	logic [RES_NUM_W-1:0] num_q;
	logic [RES_DEN_W-1:0] dres_q;
	logic                 st_q, done_q;
	logic                 div_last;

	assign trial    = {rem_q, dvd_q[MAG_WIDTH-1]} - {1'b0, dvs_q};
	assign div_last = div_run_q && (cnt_q == CW'(MAG_WIDTH - 1));
	assign pop      = (state_q == BS_IDLE) && !q_empty;
	assign done     = done_q;
	assign res_num  = num_q;
	assign res_den  = dres_q;
	assign status   = st_q;
	assign n_out    = neg_q ? (~quo_q + 1'b1) : quo_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: if (!q_empty) begin
				if (job.err || job.mag == '0) state_d = BS_OUT;
				else state_d = BS_GCD;
			end
			BS_GCD:  if (!div_run_q && y_q == '0) state_d = BS_DIVN;
			BS_DIVN: if (div_last) state_d = BS_DIVD;
			BS_DIVD: if (div_last) state_d = BS_OUT;
			BS_OUT:  state_d = BS_IDLE;
			default: state_d = BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BS_IDLE;
			div_run_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (div_last) div_run_q <= 1'b0;
			case (state_q)
				BS_IDLE: if (!q_empty) begin
					if (job.err || job.mag == '0) done_q <= 1'b1;
				end
				BS_GCD: if (!div_run_q && y_q != '0) div_run_q <= 1'b1;
				BS_DIVN, BS_DIVD: if (!div_run_q && !div_last) div_run_q <= 1'b1;
				default: ;
			endcase
			if (state_q == BS_DIVD && div_last) done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_run_q) begin
			// one quotient bit a cycle
			dvd_q <= {dvd_q[MAG_WIDTH-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
			if (!trial[MAG_WIDTH]) begin
				rem_q <= trial[MAG_WIDTH-1:0];
				quo_q <= {quo_q[MAG_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[MAG_WIDTH-2:0], dvd_q[MAG_WIDTH-1]};
				quo_q <= {quo_q[MAG_WIDTH-2:0], 1'b0};
			end
		end
		case (state_q)
			BS_IDLE: if (!q_empty) begin
				neg_q <= job.neg;
				mag_q <= job.mag;
				den_q <= job.den;
				x_q   <= job.mag;
				y_q   <= job.den;
				if (job.err) begin
					num_q  <= '0;
					dres_q <= '0;
					st_q   <= 1'b1;
				end else begin
					num_q  <= '0;
					dres_q <= RES_DEN_W'(1);
					st_q   <= 1'b0;
				end
			end
			BS_GCD: begin
				if (!div_run_q && y_q != '0) begin
					dvd_q <= x_q; dvs_q <= y_q; rem_q <= '0; quo_q <= '0; cnt_q <= '0;
				end
				if (div_last) begin
					x_q <= y_q;
					y_q <= trial[MAG_WIDTH] ? {rem_q[MAG_WIDTH-2:0], dvd_q[MAG_WIDTH-1]}
						: trial[MAG_WIDTH-1:0];
				end
			end
			BS_DIVN: begin
				if (!div_run_q && !div_last) begin
					dvd_q <= mag_q; dvs_q <= x_q; rem_q <= '0; quo_q <= '0; cnt_q <= '0;
				end
			end
			BS_DIVD: begin
				if (!div_run_q) begin
					num_q <= RES_NUM_W'(n_out);
					dvd_q <= den_q; dvs_q <= x_q; rem_q <= '0; quo_q <= '0; cnt_q <= '0;
				end
				if (div_last) dres_q <= RES_DEN_W'({quo_q[MAG_WIDTH-2:0], !trial[MAG_WIDTH]});
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/fraction_arith_reduce_unit.sv
// Top level of the fraction arithmetic and reduction unit.
// Depends on far_pkg, far_front, far_queue and far_back.
//
// One item in, one result out. The front takes an item when busy is low and
// holds busy through its multiply, sum and hand-over states, longer while the
// queue is full. A two-deep queue then feeds the back part, which runs Euclid
// and two final divisions on a shared bit-serial divider, so the front can take
// a new item while the back part still works on an earlier one. The result
// shows for one cycle with done high; the receiver cannot stall it. Errors
// give 0/0 with status high; zero gives 0/1.
module fraction_arith_reduce_unit import far_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             kind,
	input  logic [VALUE_WIDTH-1:0] a_num,
	input  logic [DEN_WIDTH-1:0]   a_den,
	input  logic [VALUE_WIDTH-1:0] b_num,
	input  logic [DEN_WIDTH-1:0]   b_den,
	output logic                   done,
	output logic [RES_NUM_W-1:0]   res_num,
	output logic [RES_DEN_W-1:0]   res_den,
	output logic                   status
);

	job_t f_job, q_job;
	logic f_push, q_pop, q_empty, q_full;

	far_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.busy(busy), .push(f_push), .job(f_job), .q_full(q_full)
	);

	far_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(f_push), .wdata(f_job),
		.pop(q_pop), .rdata(q_job), .empty(q_empty), .full(q_full)
	);

	far_back u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .job(q_job), .pop(q_pop),
		.done(done), .res_num(res_num), .res_den(res_den), .status(status)
	);

`ifndef SYNTHESIS
	a_err_den: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> res_den == '0 && res_num == '0)
		else $error("error result not 0/0");
	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		done && !status |-> res_den != '0)
		else $error("zero denominator on good result");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !q_full)
		else $error("push into full queue");
`endif

endmodule

// File: sim/fraction_arith_reduce_unit_test.sv
// Self-checking testbench for the fraction arithmetic and reduction unit.
// Drives directed and random fraction beats, predicts each reduced result.
// Depends on far_pkg and fraction_arith_reduce_unit.
module fraction_arith_reduce_unit_test;
	import far_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 1950;
	localparam int CYCLE_CAP  = 20000000;
	localparam int TAIL_WAIT  = 1000;

	typedef struct packed {
		logic [RES_NUM_W-1:0] num;
		logic [RES_DEN_W-1:0] den;
		logic                 st;
	} frac_res_t;

	typedef struct {
		op_t                    op;
		logic [VALUE_WIDTH-1:0] an;
		logic [DEN_WIDTH-1:0]   ad;
		logic [VALUE_WIDTH-1:0] bn;
		logic [DEN_WIDTH-1:0]   bd;
		logic                   typed;
		frac_res_t              want;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] kind = '0;
	logic [VALUE_WIDTH-1:0] a_num = '0;
	logic [DEN_WIDTH-1:0] a_den = '0;
	logic [VALUE_WIDTH-1:0] b_num = '0;
	logic [DEN_WIDTH-1:0] b_den = '0;
	logic done;
	logic [RES_NUM_W-1:0] res_num;
	logic [RES_DEN_W-1:0] res_den;
	logic status;

	frac_res_t pending_q[$];
	int errors = 0;
	int cycles = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int idle_pct = 0;

	fraction_arith_reduce_unit uut (.*);

	always #2 clk = ~clk;

	function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic frac_res_t reduce_frac(op_t op, logic [VALUE_WIDTH-1:0] an,
			logic [DEN_WIDTH-1:0] ad, logic [VALUE_WIDTH-1:0] bn,
			logic [DEN_WIDTH-1:0] bd);
		frac_res_t r;
		longint unsigned am, bm, p, q, mag, den, g;
		bit aneg, bneg, qneg, neg;
		aneg = an[VALUE_WIDTH-1];
		bneg = bn[VALUE_WIDTH-1];
		am = aneg ? (longint'(1) << VALUE_WIDTH) - an : an;
		bm = bneg ? (longint'(1) << VALUE_WIDTH) - bn : bn;
		r = '{num: '0, den: '0, st: 1'b1};
		if (ad == 0 || bd == 0)
			return r;
		case (op)
			OP_ADD, OP_SUB: begin
				p = am * bd;
				q = bm * ad;
				qneg = (op == OP_SUB) ? !bneg : bneg;
				if (aneg == qneg) begin
					mag = p + q;
					neg = aneg;
				end else if (p >= q) begin
					mag = p - q;
					neg = aneg;
				end else begin
					mag = q - p;
					neg = qneg;
				end
				den = ad * bd;
			end
			OP_MUL: begin
				mag = am * bm;
				neg = aneg ^ bneg;
				den = ad * bd;
			end
			default: begin
				if (bm == 0)
					return r;
				mag = am * bd;
				neg = aneg ^ bneg;
				den = ad * bm;
			end
		endcase
		if (mag == 0) begin
			r = '{num: '0, den: 1, st: 1'b0};
			return r;
		end
		g = euclid(mag, den);
		mag = mag / g;
		den = den / g;
		r.num = neg ? -mag[RES_NUM_W-1:0] : mag[RES_NUM_W-1:0];
		r.den = den[RES_DEN_W-1:0];
		r.st = 1'b0;
		return r;
	endfunction

	// one beat: optional random gap, then hold start until accepted
	task automatic send_beat(op_t op, logic [VALUE_WIDTH-1:0] an, logic [DEN_WIDTH-1:0] ad,
			logic [VALUE_WIDTH-1:0] bn, logic [DEN_WIDTH-1:0] bd);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= op;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		do @(posedge clk); while (busy);
		pending_q.push_back(reduce_frac(op, an, ad, bn, bd));
		beats_sent++;
	endtask

	// drop start and hold until every expected result has come
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
	endtask

	function automatic logic [DEN_WIDTH-1:0] pick_den();
		case ($urandom_range(9))
			0: return DEN_WIDTH'(1);
			1: return {DEN_WIDTH{1'b1}};
			2: return DEN_WIDTH'($urandom_range(1, 12));
			3: return DEN_WIDTH'(0);
			default: return DEN_WIDTH'($urandom_range(1, (1 << DEN_WIDTH) - 1));
		endcase
	endfunction

	function automatic logic [VALUE_WIDTH-1:0] pick_num();
		case ($urandom_range(9))
			0: return '0;
			1: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
			2: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
			3: return VALUE_WIDTH'($signed($urandom_range(0, 24)) - 12);
			default: return VALUE_WIDTH'($urandom);
		endcase
	endfunction

	// result checker: strobe lasts one cycle, sample at the edge ending it
	always @(posedge clk) begin
		frac_res_t w;
		if (arst_n && done) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result num=%0d den=%0d status=%0b",
					$time, $signed(res_num), res_den, status);
				errors++;
			end else begin
				w = pending_q.pop_front();
				if (res_num !== w.num) begin
					$display("%0t: res_num expected %0d got %0d", $time,
						$signed(w.num), $signed(res_num));
					errors++;
				end
				if (res_den !== w.den) begin
					$display("%0t: res_den expected %0d got %0d", $time, w.den, res_den);
					errors++;
				end
				if (status !== w.st) begin
					$display("%0t: status expected %0b got %0b", $time, w.st, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("[fraction_arith_reduce_unit] ERROR");
			$finish;
		end
	end

	localparam logic [VALUE_WIDTH-1:0] NMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] NMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [DEN_WIDTH-1:0]   DMAX = {DEN_WIDTH{1'b1}};
	localparam frac_res_t R_ERR  = '{num: '0, den: '0, st: 1'b1};
	localparam frac_res_t R_ZERO = '{num: '0, den: 1, st: 1'b0};
	localparam frac_res_t R_NONE = '{num: '0, den: '0, st: 1'b0};

	vec_t directed[] = '{
		'{OP_ADD, 16'sd0,  15'd1,  16'sd0,  15'd1,  1'b1, R_ZERO},
		'{OP_ADD, 16'sd1,  15'd2,  16'sd1,  15'd2,  1'b1, '{32'sd1, 31'd1, 1'b0}},
		'{OP_SUB, 16'sd3,  15'd4,  16'sd3,  15'd4,  1'b1, R_ZERO},
		'{OP_SUB, 16'sd1,  15'd3,  16'sd1,  15'd2,  1'b1, '{-32'sd1, 31'd6, 1'b0}},
		'{OP_MUL, 16'sd2,  15'd3,  16'sd3,  15'd2,  1'b1, '{32'sd1, 31'd1, 1'b0}},
		'{OP_MUL, -16'sd5, 15'd7,  16'sd0,  15'd9,  1'b1, R_ZERO},
		'{OP_DIV, 16'sd1,  15'd2,  16'sd0,  15'd5,  1'b1, R_ERR},
		'{OP_DIV, -16'sd1, 15'd2,  -16'sd1, 15'd4,  1'b1, '{32'sd2, 31'd1, 1'b0}},
		'{OP_ADD, 16'sd1,  15'd0,  16'sd1,  15'd1,  1'b1, R_ERR},
		'{OP_SUB, 16'sd1,  15'd1,  16'sd1,  15'd0,  1'b1, R_ERR},
		'{OP_MUL, 16'sd0,  15'd0,  16'sd0,  15'd0,  1'b1, R_ERR},
		'{OP_DIV, 16'sd0,  15'd0,  16'sd0,  15'd3,  1'b1, R_ERR},
		'{OP_MUL, NMIN,    15'd1,  NMIN,    15'd1,  1'b1, '{32'sd1073741824, 31'd1, 1'b0}},
		'{OP_MUL, NMAX,    DMAX,   NMAX,    DMAX,   1'b1, '{32'sd1, 31'd1, 1'b0}},
		'{OP_ADD, NMAX,    DMAX,   NMAX,    DMAX,   1'b0, R_NONE},
		'{OP_ADD, NMIN,    15'd1,  NMIN,    15'd1,  1'b0, R_NONE},
		'{OP_SUB, NMIN,    15'd1,  NMAX,    15'd1,  1'b0, R_NONE},
		'{OP_SUB, NMAX,    DMAX,   NMIN,    15'd1,  1'b0, R_NONE},
		'{OP_MUL, NMAX,    15'd1,  NMIN,    DMAX,   1'b0, R_NONE},
		'{OP_DIV, NMIN,    DMAX,   NMAX,    15'd1,  1'b0, R_NONE},
		'{OP_DIV, NMAX,    15'd1,  NMIN,    DMAX,   1'b0, R_NONE},
		'{OP_ADD, 16'sd7,  15'd12, -16'sd5, 15'd18, 1'b0, R_NONE},
		'{OP_DIV, 16'sd21, 15'd35, 16'sd14, 15'd15, 1'b0, R_NONE}
	};

	initial begin
		int phase_len;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].typed &&
					reduce_frac(directed[i].op, directed[i].an, directed[i].ad,
						directed[i].bn, directed[i].bd) != directed[i].want) begin
				$display("%0t: table row %0d disagrees with prediction", $time, i);
				errors++;
			end
			send_beat(directed[i].op, directed[i].an, directed[i].ad,
				directed[i].bn, directed[i].bd);
		end
		wait_drained();

		phase_len = N_RANDOM / 3;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 0)
				idle_pct = 35;
			else if (i == phase_len)
				idle_pct = 60;
			else if (i == 2 * phase_len)
				idle_pct = 0;
			// hold off until the unit has drained now and then
			if (i % 500 == 250)
				wait_drained();
			send_beat(op_t'($urandom_range(3)), pick_num(), pick_den(), pick_num(),
				pick_den());
		end

		wait_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		$display("Sent %0d fraction beats over all four operations, %0d results checked.",
			beats_sent, results_seen);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("[fraction_arith_reduce_unit] OK");
		end else begin
			$display("[fraction_arith_reduce_unit] ERROR");
		end
		$finish;
	end
endmodule
